### rtl/core/trle_pkg.sv
// Shared types and constants for the run-length coded TGA pixel decoder.
// No dependencies; imported by every module under rtl/core.
package trle_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYTES_PER_PIXEL = 1'b0,
		REG_PIXEL_COUNT     = 1'b1
	} cfg_reg_t;

	localparam logic [2:0]  BPP_RESET         = 3'd3;
	localparam logic [2:0]  BPP_WIDE          = 3'd4;
	localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;

	typedef struct packed {
		logic [2:0]  bytes_per_pixel;
		logic [31:0] pixel_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_res;
		logic       image_done;
		logic       run_clipped;
	} res_t;

endpackage

### rtl/core/trle_decode.sv
// Packet parser and pixel assembler: one stream byte per step.
// Holds the decode state and the color byte store. Depends on trle_pkg.
module trle_decode import trle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	input  cfg_t       cfg,
	output logic       res_fire,
	output res_t       res
);

	logic        expecting_q;
	logic        is_run_q;
	logic        finished_q;
	logic [7:0]  left_q;
	logic [1:0]  slot_q;
	logic [31:0] done_q;
	logic [7:0]  color_q [4];

	logic        size4;
	logic [1:0]  slot_n;
	logic        complete;
	logic [32:0] diff;
	logic        remain_zero;
	logic [31:0] remaining;
	logic        rem_lt_left;
	logic [7:0]  repeat_cnt;
	logic        clipped;
	logic [7:0]  left_next;
	logic        image_done;
	logic        color_step;
	logic        pixel_step;
	logic [7:0]  color_n [4];

	// sizes below 3 act as 3, above 4 act as 4
	assign size4 = cfg.bytes_per_pixel >= BPP_WIDE;
	assign slot_n = slot_q + 2'd1;
	assign complete = (slot_n == 2'd0) || (!size4 && slot_n == 2'd3);

	assign diff = {1'b0, cfg.pixel_count} - {1'b0, done_q};
	assign remaining = diff[31:0];
	assign remain_zero = diff[32] || (diff[31:0] == 32'd0);
	assign rem_lt_left = remaining < {24'd0, left_q};

	always_comb begin
		if (is_run_q) begin
			repeat_cnt = rem_lt_left ? remaining[7:0] : left_q;
			clipped    = rem_lt_left;
			left_next  = 8'd0;
		end else begin
			repeat_cnt = 8'd1;
			clipped    = (left_q > 8'd1) && (remaining == 32'd1);
			left_next  = (left_q == 8'd0) ? 8'd0 : left_q - 8'd1;
		end
	end

	// repeat never exceeds what remains, so equality means the image is full
	assign image_done = ({24'd0, repeat_cnt} == remaining);

	assign color_step = step && !finished_q && !expecting_q;
	assign pixel_step = color_step && complete;
	assign res_fire   = pixel_step && !remain_zero;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			color_n[i] = (slot_q == 2'(i)) ? byte_s1 : color_q[i];
		end
	end

	always_comb begin
		res.red         = color_n[2];
		res.green       = color_n[1];
		res.blue        = color_n[0];
		res.alpha       = size4 ? color_n[3] : 8'd0;
		res.repeat_res  = repeat_cnt;
		res.image_done  = image_done;
		res.run_clipped = clipped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expecting_q <= 1'b1;
			is_run_q    <= 1'b0;
			finished_q  <= 1'b0;
			left_q      <= 8'd0;
			slot_q      <= 2'd0;
			done_q      <= 32'd0;
		end else if (step && !finished_q) begin
			if (expecting_q) begin
				// raw: h+1, run: h-127; both equal low seven bits plus one
				is_run_q    <= byte_s1[7];
				left_q      <= {1'b0, byte_s1[6:0]} + 8'd1;
				slot_q      <= 2'd0;
				expecting_q <= 1'b0;
			end else begin
				slot_q <= complete ? 2'd0 : slot_n;
				if (complete) begin
					if (remain_zero) begin
						finished_q <= 1'b1;
					end else begin
						left_q      <= left_next;
						expecting_q <= (left_next == 8'd0);
						done_q      <= done_q + {24'd0, repeat_cnt};
						if (image_done) begin
							finished_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (color_step) begin
			color_q[slot_q] <= byte_s1;
		end
	end

`ifndef SYNTHESIS
	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("decoder left finished state without reset");

	a_no_result_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !res_fire)
		else $error("result produced after image end");

	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |-> (res.repeat_res != 8'd0 && res.repeat_res <= 8'd128))
		else $error("repeat count out of range");

	a_raw_single: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && !is_run_q) |-> (res.repeat_res == 8'd1))
		else $error("raw pixel with repeat other than one");
`endif

endmodule

### rtl/core/trle_out_stage.sv
// Result register between the decoder and the result channel.
// Decides when the input stage may advance. Depends on trle_pkg.
module trle_out_stage import trle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load_valid,
	input  res_t load_res,
	input  logic res_stall,
	output logic advance,
	output logic res_valid,
	output res_t res_q
);

	logic res_valid_q;

	// the register can take a new value when empty or being drained
	assign advance   = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

### rtl/core/tga_rle_pixel_decoder.sv
// Run-length coded TGA pixel decoder, top level: input register, config registers.
// A byte accepted into the input register is decoded into the result register, which can stall.
// Throughput: one stream byte per cycle while the result side takes transactions.
// Each byte needs only a short state update between input and result registers.
// Reset (arst_n low, asynchronous): decoder waits for a packet header, bytes_per_pixel 3,
// pixel_count 1, no pixels done; the color store is not cleared.
module tga_rle_pixel_decoder import trle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  logic [7:0]            data_byte,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic [7:0]            alpha,
	output logic [7:0]            repeat_res,
	output logic                  image_done,
	output logic                  run_clipped,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	logic       dec_fire;
	res_t       dec_res;
	res_t       out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_pixel <= BPP_RESET;
			cfg_q.pixel_count     <= PIXEL_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_data[2:0];
				REG_PIXEL_COUNT:     cfg_q.pixel_count     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign step      = valid_s1 && advance;
	assign src_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			byte_s1 <= data_byte;
		end
	end

	trle_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_s1  (byte_s1),
		.cfg      (cfg_q),
		.res_fire (dec_fire),
		.res      (dec_res)
	);

	trle_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (step && dec_fire),
		.load_res   (dec_res),
		.res_stall  (res_stall),
		.advance    (advance),
		.res_valid  (res_valid),
		.res_q      (out_res)
	);

	assign red         = out_res.red;
	assign green       = out_res.green;
	assign blue        = out_res.blue;
	assign alpha       = out_res.alpha;
	assign repeat_res  = out_res.repeat_res;
	assign image_done  = out_res.image_done;
	assign run_clipped = out_res.run_clipped;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for tga_rle_pixel_decoder: byte-stream driver, result monitor, pixel predictor.
// Depends on trle_pkg (register indexes, result struct) and the decoder RTL.
module tb;
	import trle_pkg::*;

	localparam int unsigned STUCK_LIMIT = 2000;
	localparam int unsigned HOLD_LEN    = 100;
	localparam int unsigned SETTLE      = 6;
	localparam int unsigned N_PHASES    = 10;

	typedef enum int unsigned {
		END_RUN_CLIP,
		END_RAW_CLIP,
		END_NOTHING_LEFT
	} end_case_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  src_valid = 1'b0;
	logic                  src_stall;
	logic [7:0]            data_byte = 8'h00;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [7:0]            red, green, blue, alpha, repeat_res;
	logic                  image_done, run_clipped;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tga_rle_pixel_decoder u_dut (
		.clk, .arst_n,
		.src_valid, .src_stall, .data_byte,
		.res_valid, .res_stall,
		.red, .green, .blue, .alpha, .repeat_res, .image_done, .run_clipped,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// bytes waiting to be offered, pixels waiting to come out
	logic [7:0] stream_bytes[$];
	res_t       expected_pixels[$];

	logic idle_en  = 1'b1;
	logic hold_req = 1'b0;
	logic hold_done;
	int unsigned hold_cnt;
	int unsigned src_gap, res_burst;
	int unsigned stuck_cycles = 0;
	int unsigned errors = 0;
	int unsigned n_bytes = 0;
	int unsigned n_pixels = 0;
	int unsigned n_clipped = 0;
	int unsigned n_settings = 0;

	// decoder shadow: configuration and packet state
	logic [2:0]  bpp_reg = BPP_RESET;
	logic [31:0] count_reg = PIXEL_COUNT_RESET;
	logic        dec_want_hdr = 1'b1;
	logic        dec_is_run = 1'b0;
	logic        dec_ended = 1'b0;
	logic [7:0]  dec_left = 8'd0;
	logic [1:0]  dec_slot = 2'd0;
	logic [7:0]  dec_store[4] = '{default: 8'd0};
	logic [31:0] dec_done = 32'd0;

	task automatic report(string msg);
		// output is capped, the count is not
		if (errors < 40)
			$display("%0t MISMATCH %s", $realtime, msg);
		errors++;
	endtask

	function automatic int unsigned pixel_bytes();
		if (bpp_reg < 3'd3) return 3;
		if (bpp_reg > BPP_WIDE) return 4;
		return {29'd0, bpp_reg};
	endfunction

	task automatic decode_byte(logic [7:0] b);
		int unsigned size, remaining, rep;
		logic clip;
		res_t px;
		if (dec_ended)
			return;
		if (dec_want_hdr) begin
			dec_is_run = b[7];
			dec_left = b[7] ? b - 8'd127 : b + 8'd1;
			dec_slot = 2'd0;
			dec_want_hdr = 1'b0;
			return;
		end
		dec_store[dec_slot] = b;
		dec_slot = dec_slot + 2'd1;
		size = pixel_bytes();
		if (dec_slot != 2'd0 && dec_slot < size)
			return;
		dec_slot = 2'd0;
		remaining = (dec_done < count_reg) ? count_reg - dec_done : 0;
		if (remaining == 0) begin
			dec_ended = 1'b1;
			return;
		end
		if (dec_is_run) begin
			rep = (dec_left <= remaining) ? {24'd0, dec_left} : remaining;
			clip = dec_left > remaining;
			dec_left = 8'd0;
		end else begin
			rep = 1;
			clip = (dec_left > 8'd1) && (remaining == 1);
			dec_left = (dec_left > 8'd0) ? dec_left - 8'd1 : 8'd0;
		end
		if (dec_left == 8'd0)
			dec_want_hdr = 1'b1;
		dec_done = dec_done + rep;
		if (dec_done >= count_reg)
			dec_ended = 1'b1;
		px.red = dec_store[2];
		px.green = dec_store[1];
		px.blue = dec_store[0];
		px.alpha = (size == 4) ? dec_store[3] : 8'd0;
		px.repeat_res = rep[7:0];
		px.image_done = dec_ended;
		px.run_clipped = clip;
		expected_pixels.push_back(px);
	endtask

	task automatic check_pixel();
		res_t want;
		if (expected_pixels.size() == 0) begin
			report("pixel transaction with nothing pending");
			return;
		end
		want = expected_pixels.pop_front();
		n_pixels++;
		if (run_clipped)
			n_clipped++;
		if (red != want.red)
			report($sformatf("red got %0h want %0h", red, want.red));
		if (green != want.green)
			report($sformatf("green got %0h want %0h", green, want.green));
		if (blue != want.blue)
			report($sformatf("blue got %0h want %0h", blue, want.blue));
		if (alpha != want.alpha)
			report($sformatf("alpha got %0h want %0h", alpha, want.alpha));
		if (repeat_res != want.repeat_res)
			report($sformatf("repeat got %0d want %0d", repeat_res, want.repeat_res));
		if (image_done != want.image_done)
			report($sformatf("image_done got %0b want %0b", image_done, want.image_done));
		if (run_clipped != want.run_clipped)
			report($sformatf("run_clipped got %0b want %0b", run_clipped, want.run_clipped));
	endtask

	// byte driver: payload holds while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			data_byte <= 8'h00;
			src_gap <= 0;
		end else if (src_valid && src_stall) begin
		end else if (src_gap != 0) begin
			src_valid <= 1'b0;
			src_gap <= src_gap - 1;
		end else if (stream_bytes.size() != 0 && idle_en && $urandom_range(0, 9) == 0) begin
			src_valid <= 1'b0;
			src_gap <= $urandom_range(0, 6);
		end else if (stream_bytes.size() != 0) begin
			src_valid <= 1'b1;
			data_byte <= stream_bytes.pop_front();
		end else begin
			src_valid <= 1'b0;
		end
	end

	// result-side stall: random bursts, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_burst <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			res_stall <= 1'b1;
			if (hold_cnt == HOLD_LEN)
				hold_done <= 1'b1;
			else
				hold_cnt <= hold_cnt + 1;
		end else if (res_burst != 0) begin
			res_stall <= 1'b1;
			res_burst <= res_burst - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			res_stall <= 1'b1;
			res_burst <= $urandom_range(0, 6);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// monitor: predict on each accepted byte, check each accepted pixel
	always @(posedge clk) begin
		if (arst_n && src_valid && !src_stall) begin
			decode_byte(data_byte);
			n_bytes++;
		end
		if (arst_n && res_valid && !res_stall)
			check_pixel();
		if ((src_valid && !src_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin : watchdog
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [7:0] rand_byte();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_BYTES_PER_PIXEL)
			bpp_reg = val[2:0];
		else
			count_reg = val;
	endtask

	// all bytes taken, all pixels seen, then a settling wait for the pipeline
	task automatic wait_idle();
		while (stream_bytes.size() != 0 || src_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(logic [2:0] bpp, logic [31:0] cnt, bit count_first);
		if (count_first) begin
			write_reg(REG_PIXEL_COUNT, cnt);
			write_reg(REG_BYTES_PER_PIXEL, {29'd0, bpp});
		end else begin
			write_reg(REG_BYTES_PER_PIXEL, {29'd0, bpp});
			write_reg(REG_PIXEL_COUNT, cnt);
		end
		n_settings++;
	endtask

	// well-formed packets with random colors, mixed with stray bytes unless clean
	task automatic queue_stream(int unsigned n, bit clean);
		int unsigned count, hdr, npix, size;
		count = 0;
		size = pixel_bytes();
		while (count < n) begin
			if (!clean && $urandom_range(0, 4) == 0) begin
				stream_bytes.push_back(rand_byte());
				count++;
			end else begin
				if ($urandom_range(0, 1)) begin
					hdr = 128 + $urandom_range(0, 127);
					npix = 1;
				end else begin
					hdr = (!clean && $urandom_range(0, 9) == 0) ?
						$urandom_range(0, 127) : $urandom_range(0, 3);
					npix = hdr + 1;
				end
				stream_bytes.push_back(hdr[7:0]);
				count++;
				for (int p = 0; p < npix && (clean || count < n); p++)
					for (int k = 0; k < size; k++) begin
						stream_bytes.push_back(rand_byte());
						count++;
					end
			end
		end
	endtask

	initial begin : stimulus
		logic [2:0]  bpp_list[N_PHASES];
		logic [31:0] cnt;
		end_case_t   end_case;
		int unsigned size;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bpp_list = '{3'd4, 3'd0, 3'd7, 3'd3, 3'd1, 3'd5, 3'd2, 3'd6, 3'd4, 3'd3};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// pixel size left at its reset value of 3
		write_reg(REG_PIXEL_COUNT, 32'hFFFF_FFFF);
		n_settings++;
		stream_bytes = '{8'h00, 8'h00, 8'hFF, 8'h80,
			8'h80, 8'hFF, 8'h00, 8'h7F,
			8'hFF, 8'h12, 8'h34, 8'h56,
			8'h01, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		wait_idle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph % 3)
				0: cnt = 32'd4294836225;
				1: cnt = 32'hFFFF_FFFF;
				default: cnt = dec_done + 100000 + $urandom_range(0, 1000000);
			endcase
			set_config(bpp_list[ph], cnt, ph[0]);
			if (ph >= N_PHASES - 2)
				idle_en <= 1'b0;
			if (ph == 2) begin
				// long hold on the result side while bytes keep coming
				hold_req <= 1'b1;
				queue_stream(42, 1'b0);
				while (!hold_done)
					@(posedge clk);
				hold_req <= 1'b0;
			end else if (ph == 5) begin
				// sender pauses until every pixel has drained
				queue_stream(20, 1'b0);
				wait_idle();
				queue_stream(22, 1'b0);
			end else begin
				queue_stream(42, ph == N_PHASES - 1);
			end
			wait_idle();
		end

		// line up on a packet header before bringing the image to its end
		while (!dec_want_hdr && !dec_ended) begin
			stream_bytes.push_back(8'h5A);
			wait_idle();
		end

		end_case = end_case_t'($urandom_range(0, 2));
		case (end_case)
			END_RUN_CLIP: cnt = dec_done + $urandom_range(1, 20);
			END_RAW_CLIP: cnt = dec_done + $urandom_range(1, 3);
			default: cnt = $urandom_range(0, 1) ? 32'd0 :
				dec_done - $urandom_range(0, (dec_done > 50) ? 50 : dec_done);
		endcase
		set_config($urandom_range(0, 1) ? BPP_WIDE : BPP_RESET, cnt, 1'b1);
		size = pixel_bytes();
		case (end_case)
			END_RUN_CLIP: stream_bytes.push_back(8'hFF);
			END_RAW_CLIP: stream_bytes.push_back(8'h7F);
			default: stream_bytes.push_back(rand_byte());
		endcase
		repeat (8 * size)
			stream_bytes.push_back(rand_byte());
		// everything past the end of the image must be dropped
		repeat (20)
			stream_bytes.push_back(rand_byte());
		wait_idle();
		repeat (20) @(posedge clk);

		$display("coverage: %0d bytes under %0d register settings, %0d pixels checked, %0d clipped",
			n_bytes, n_settings, n_pixels, n_clipped);
		$display("coverage: image end reached %0b via end case %s", dec_ended, end_case.name());
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
